@@ hdl/kpd_pkg.sv @@
// shared types, constants and register codes for the keypad scan debouncer
`timescale 1ns / 1ps
`default_nettype none
package kpd_pkg;

   localparam int MAX_ROWS        = 4;
   localparam int MAX_COLUMNS     = 4;
   localparam int KEY_COUNT       = MAX_ROWS * MAX_COLUMNS;
   localparam int TIME_WIDTH      = 32;
   localparam int FIELD_ROWS      = 4;
   localparam int FIELD_COLUMNS   = 4;
   localparam int COUNT_WIDTH     = 3;
   localparam int INTERVAL_WIDTH  = 16;
   localparam int CSR_INDEX_WIDTH = 2;
   localparam int CSR_DATA_WIDTH  = 16;
   localparam int TOTAL_WIDTH     = 2 * COUNT_WIDTH;

   typedef logic [TIME_WIDTH-1:0]                 time_type;
   typedef logic [KEY_COUNT-1:0]                  keys_type;
   typedef logic [COUNT_WIDTH-1:0]                count_type;
   typedef logic [INTERVAL_WIDTH-1:0]             interval_type;
   typedef logic [FIELD_COLUMNS-1:0]              col_levels_type;
   typedef logic [FIELD_ROWS*FIELD_COLUMNS-1:0]   levels_type;
   typedef logic [CSR_INDEX_WIDTH-1:0]            csr_index_type;
   typedef logic [CSR_DATA_WIDTH-1:0]             csr_data_type;
   typedef logic [TOTAL_WIDTH-1:0]                total_type;

   // request opcodes
   localparam logic OP_SCAN = 1'b0;
   localparam logic OP_INIT = 1'b1;

   // register indexes
   localparam csr_index_type CSR_MIN_SCAN_INTERVAL = 2'd0;
   localparam csr_index_type CSR_DEBOUNCE          = 2'd1;
   localparam csr_index_type CSR_ROW_COUNT         = 2'd2;
   localparam csr_index_type CSR_COLUMN_COUNT      = 2'd3;

   // register reset values
   localparam interval_type MIN_SCAN_INTERVAL_RESET = 16'd10;
   localparam interval_type DEBOUNCE_RESET          = 16'd20;
   localparam count_type    ROW_COUNT_RESET         = 3'd4;
   localparam count_type    COLUMN_COUNT_RESET      = 3'd4;

   typedef struct packed {
      interval_type min_scan_interval_ms;
      interval_type debounce_ms;
      count_type    row_count;
      count_type    column_count;
   } cfg_type;

endpackage
`default_nettype wire

@@ hdl/kpd_req_if.sv @@
// request channel: opcode, time stamp and the column levels of each row
`timescale 1ns / 1ps
`default_nettype none
interface kpd_req_if import kpd_pkg::*; ();
   logic           valid;
   logic           ready;
   logic           opcode;
   time_type       now_ms;
   col_levels_type row0_columns;
   col_levels_type row1_columns;
   col_levels_type row2_columns;
   col_levels_type row3_columns;

   modport source (output valid, opcode, now_ms, row0_columns, row1_columns,
                   row2_columns, row3_columns, input ready);
   modport sink   (input valid, opcode, now_ms, row0_columns, row1_columns,
                   row2_columns, row3_columns, output ready);
endinterface
`default_nettype wire

@@ hdl/kpd_rsp_if.sv @@
// response channel: debounced key vector and status flags
`timescale 1ns / 1ps
`default_nettype none
interface kpd_rsp_if import kpd_pkg::*; ();
   logic     valid;
   logic     ready;
   keys_type key_state;
   logic     changed;
   logic     scanned;

   modport source (output valid, key_state, changed, scanned, input ready);
   modport sink   (input valid, key_state, changed, scanned, output ready);
endinterface
`default_nettype wire

@@ hdl/kpd_csr_if.sv @@
// register write channel
`timescale 1ns / 1ps
`default_nettype none
interface kpd_csr_if import kpd_pkg::*; ();
   logic          valid;
   logic          ready;
   csr_index_type index;
   csr_data_type  data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

@@ hdl/kpd_key_update.sv @@
// per-key debounce decision for one accepted scan
`timescale 1ns / 1ps
`default_nettype none
module kpd_key_update import kpd_pkg::*; (
   input  wire cfg_type    cfg,
   input  wire time_type   now_ms,
   input  wire levels_type levels,
   input  wire keys_type   stable_keys,
   input  wire time_type   agree_time [KEY_COUNT],
   output keys_type        next_keys,
   output keys_type        refresh
);

   count_type rows_eff;
   count_type cols_eff;
   total_type key_total;

   always_comb begin
      rows_eff = (cfg.row_count > count_type'(MAX_ROWS)) ?
                 count_type'(MAX_ROWS) : cfg.row_count;
      cols_eff = (cfg.column_count > count_type'(MAX_COLUMNS)) ?
                 count_type'(MAX_COLUMNS) : cfg.column_count;
      key_total = total_type'(rows_eff) * total_type'(cols_eff);
   end

   for (genvar k = 0; k < KEY_COUNT; k++) begin : g_key
      // row and column of this bit position for each column count
      localparam int R1 = k;
      localparam int R2 = k / 2;
      localparam int R3 = k / 3;
      localparam int R4 = k / 4;
      localparam int C2 = k % 2;
      localparam int C3 = k % 3;
      localparam int C4 = k % 4;

      logic     lvl1, lvl2, lvl3, lvl4;
      logic     level, in_use, pressed, held, stale, take;
      time_type elapsed;

      // rows beyond the input fields read as released
      if (R1 < FIELD_ROWS) begin : g_l1
         assign lvl1 = levels[R1*FIELD_COLUMNS];
      end else begin : g_n1
         assign lvl1 = 1'b1;
      end
      if (R2 < FIELD_ROWS) begin : g_l2
         assign lvl2 = levels[R2*FIELD_COLUMNS + C2];
      end else begin : g_n2
         assign lvl2 = 1'b1;
      end
      if (R3 < FIELD_ROWS) begin : g_l3
         assign lvl3 = levels[R3*FIELD_COLUMNS + C3];
      end else begin : g_n3
         assign lvl3 = 1'b1;
      end
      if (R4 < FIELD_ROWS) begin : g_l4
         assign lvl4 = levels[R4*FIELD_COLUMNS + C4];
      end else begin : g_n4
         assign lvl4 = 1'b1;
      end

      always_comb begin
         case (cols_eff)
            3'd1:    level = lvl1;
            3'd2:    level = lvl2;
            3'd3:    level = lvl3;
            3'd4:    level = lvl4;
            default: level = 1'b1;
         endcase
         in_use  = total_type'(k) < key_total;
         pressed = ~level;
         held    = stable_keys[k];
         elapsed = now_ms - agree_time[k];
         stale   = elapsed > time_type'(cfg.debounce_ms);
         take    = (pressed == held) || stale;
         next_keys[k] = in_use & (take ? pressed : held);
         refresh[k]   = in_use & take;
      end
   end

endmodule
`default_nettype wire

@@ hdl/keypad_scan_debounce.sv @@
// keypad scan debouncer top level: handshakes, state registers and result register
`timescale 1ns / 1ps
`default_nettype none
//  channel  dir  payload                                         accepted when
//  req_if   in   opcode, now_ms, row0..row3_columns              valid && ready
//  rsp_if   out  key_state, changed, scanned                     valid && ready
//  csr_if   in   index, data                                     valid && ready
//
//  one request per cycle while rsp_if.ready is high; responses are registered
//  the debounce decision for all keys sits between the input register and the
//  result register, and the key state is updated in that same cycle
//  reset loads register defaults and clears key state, scan time and agreement times
//  a stalled response holds; one more request is taken into the input register,
//  then req_if.ready drops until the response is taken
module keypad_scan_debounce import kpd_pkg::*; (
   input  wire logic clock,
   input  wire logic reset,
   kpd_req_if.sink   req_if,
   kpd_rsp_if.source rsp_if,
   kpd_csr_if.sink   csr_if
);

   // configuration
   cfg_type cfg_ff, cfg_in;

   // input register
   logic       s1_valid_ff, s1_valid_in;
   logic       s1_opcode_ff, s1_opcode_in;
   time_type   s1_now_ff, s1_now_in;
   levels_type s1_levels_ff, s1_levels_in;

   // debounce state
   keys_type stable_ff, stable_in;
   time_type last_scan_ff, last_scan_in;
   time_type agree_ff [KEY_COUNT];
   time_type agree_in [KEY_COUNT];

   // result register
   logic     rsp_valid_ff, rsp_valid_in;
   keys_type rsp_keys_ff, rsp_keys_in;
   logic     rsp_changed_ff, rsp_changed_in;
   logic     rsp_scanned_ff, rsp_scanned_in;

   logic     req_fire;
   logic     s1_fire;
   logic     rate_ok;
   time_type scan_elapsed;
   keys_type next_keys;
   keys_type refresh;

   kpd_key_update u_key_update (
      .cfg         (cfg_ff),
      .now_ms      (s1_now_ff),
      .levels      (s1_levels_ff),
      .stable_keys (stable_ff),
      .agree_time  (agree_ff),
      .next_keys   (next_keys),
      .refresh     (refresh)
   );

   assign csr_if.ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_if.valid) begin
         unique case (csr_if.index)
            CSR_MIN_SCAN_INTERVAL: cfg_in.min_scan_interval_ms = csr_if.data;
            CSR_DEBOUNCE:          cfg_in.debounce_ms = csr_if.data;
            CSR_ROW_COUNT:         cfg_in.row_count = csr_if.data[COUNT_WIDTH-1:0];
            CSR_COLUMN_COUNT:      cfg_in.column_count = csr_if.data[COUNT_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      s1_fire       = s1_valid_ff && (!rsp_valid_ff || rsp_if.ready);
      req_if.ready  = !s1_valid_ff || s1_fire;
      req_fire      = req_if.valid && req_if.ready;

      s1_valid_in  = req_fire ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_ff);
      s1_opcode_in = s1_opcode_ff;
      s1_now_in    = s1_now_ff;
      s1_levels_in = s1_levels_ff;
      if (req_fire) begin
         s1_opcode_in = req_if.opcode;
         s1_now_in    = req_if.now_ms;
         s1_levels_in = {req_if.row3_columns, req_if.row2_columns,
                         req_if.row1_columns, req_if.row0_columns};
      end

      scan_elapsed = s1_now_ff - last_scan_ff;
      rate_ok      = scan_elapsed >= time_type'(cfg_ff.min_scan_interval_ms);

      stable_in    = stable_ff;
      last_scan_in = last_scan_ff;
      for (int k = 0; k < KEY_COUNT; k++) begin
         agree_in[k] = agree_ff[k];
      end

      rsp_valid_in   = s1_fire ? 1'b1 : (rsp_if.ready ? 1'b0 : rsp_valid_ff);
      rsp_keys_in    = rsp_keys_ff;
      rsp_changed_in = rsp_changed_ff;
      rsp_scanned_in = rsp_scanned_ff;

      if (s1_fire) begin
         rsp_keys_in    = stable_ff;
         rsp_changed_in = 1'b0;
         rsp_scanned_in = 1'b0;
         if (s1_opcode_ff == OP_INIT) begin
            last_scan_in = s1_now_ff;
            for (int k = 0; k < KEY_COUNT; k++) begin
               agree_in[k] = s1_now_ff;
            end
         end else if (rate_ok) begin
            last_scan_in = s1_now_ff;
            stable_in    = next_keys;
            for (int k = 0; k < KEY_COUNT; k++) begin
               if (refresh[k]) begin
                  agree_in[k] = s1_now_ff;
               end
            end
            rsp_keys_in    = next_keys;
            rsp_changed_in = next_keys != stable_ff;
            rsp_scanned_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.min_scan_interval_ms <= MIN_SCAN_INTERVAL_RESET;
         cfg_ff.debounce_ms          <= DEBOUNCE_RESET;
         cfg_ff.row_count            <= ROW_COUNT_RESET;
         cfg_ff.column_count         <= COLUMN_COUNT_RESET;
         s1_valid_ff                 <= 1'b0;
         rsp_valid_ff                <= 1'b0;
         stable_ff                   <= '0;
         last_scan_ff                <= '0;
         for (int k = 0; k < KEY_COUNT; k++) begin
            agree_ff[k] <= '0;
         end
      end else begin
         cfg_ff       <= cfg_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         stable_ff    <= stable_in;
         last_scan_ff <= last_scan_in;
         for (int k = 0; k < KEY_COUNT; k++) begin
            agree_ff[k] <= agree_in[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      s1_opcode_ff   <= s1_opcode_in;
      s1_now_ff      <= s1_now_in;
      s1_levels_ff   <= s1_levels_in;
      rsp_keys_ff    <= rsp_keys_in;
      rsp_changed_ff <= rsp_changed_in;
      rsp_scanned_ff <= rsp_scanned_in;
   end

   assign rsp_if.valid     = rsp_valid_ff;
   assign rsp_if.key_state = rsp_keys_ff;
   assign rsp_if.changed   = rsp_changed_ff;
   assign rsp_if.scanned   = rsp_scanned_ff;

endmodule
`default_nettype wire
